// ----- rtl/core/sdtq_pkg.sv -----
// Package for the sorted deadline timer queue.
// Holds the shared types, command and result codes, and fixed widths.
// No dependencies.
package sdtq_pkg;

  localparam int unsigned IdW     = 4;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned PeriodW = 20;
  localparam int unsigned DelayW  = 32;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CmdW    = 2;

  // One expire command reports at most this many timers.
  localparam int unsigned MaxPops = 16;
  localparam int unsigned PopCntW = $clog2(MaxPops);

  localparam logic [PeriodW-1:0] TickPeriodReset = PeriodW'(1000);

  typedef enum logic [CmdW-1:0] {
    CMD_TICK   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_EXPIRE = 2'd3
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_ACK     = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_NONE    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_EXPIRE
  } state_e;

  // Contents of one queue cell.
  typedef struct packed {
    logic             valid;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] dl;
  } entry_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic             remove;
    logic             insert;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] dl;
  } cell_ctl_t;

endpackage

// ----- rtl/core/sdtq_cell.sv -----
// One cell of the sorted timer chain: holds one queued timer and its deadline.
// Depends on sdtq_pkg.
module sdtq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sdtq_pkg::cell_ctl_t ctl_i,
  input  sdtq_pkg::entry_t    left_i,
  input  sdtq_pkg::entry_t    right_i,
  input  logic                left_open_i,
  input  logic                kill_i,
  output sdtq_pkg::entry_t    entry_o,
  output logic                open_o,
  output logic                kill_o
);

  logic                      valid_q, valid_d;
  logic [sdtq_pkg::IdW-1:0]   id_q, id_d;
  logic [sdtq_pkg::TimeW-1:0] dl_q, dl_d;
  logic                      match;

  assign entry_o = '{valid: valid_q, id: id_q, dl: dl_q};

  // A removal anywhere at or before this cell makes it take its right neighbor.
  assign match  = ctl_i.remove & valid_q & (id_q == ctl_i.id);
  assign kill_o = kill_i | match;

  // The new timer goes before the first cell that is empty or due no earlier.
  assign open_o = ~valid_q | (dl_q >= ctl_i.dl);

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    dl_d    = dl_q;
    if (kill_o) begin
      valid_d = right_i.valid;
      id_d    = right_i.id;
      dl_d    = right_i.dl;
    end else if (ctl_i.insert) begin
      if (left_open_i) begin
        valid_d = left_i.valid;
        id_d    = left_i.id;
        dl_d    = left_i.dl;
      end else if (open_o) begin
        valid_d = 1'b1;
        id_d    = ctl_i.id;
        dl_d    = ctl_i.dl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    dl_q <= dl_d;
  end

endmodule

// ----- rtl/core/sorted_deadline_timer_queue_top.sv -----
// Top level of the sorted deadline timer queue.
// Depends on sdtq_pkg and sdtq_cell.
//
// The block keeps a 64-bit microsecond clock and a queue of up to TIMER_SLOTS
// timers, sorted by deadline, in a row of cells with the earliest deadline in
// cell 0. A command transaction is taken when start is high and busy is low.
// Tick, delete, and an add whose id is not below TIMER_SLOTS leave the
// block idle: the acknowledge appears on the result ports in the next cycle
// and a new command may be issued in that same cycle. On a valid add, first
// every cell drops an existing copy of the timer and the cells behind it move
// one place toward the head; then, in the insert state, every cell compares
// the new deadline with its own and the cells from the insertion point onward
// move one place toward the tail. An expire enters the expire state, where
// each cycle the head cell is checked against the clock, a due timer is
// popped and reported while the whole row moves toward the head, and up to
// sixteen timers are reported per expire. If nothing is due a single result
// with kind "nothing expired" is given. Every result is shown
// for exactly one cycle with res_strobe_o high and cannot be held off by the
// receiver; last_o marks the final result of a command. The tick period
// register is written through the cfg channel, which is always ready, and
// should only be written while busy is low and no result is pending. Clock and
// deadlines wrap modulo 2^64 and are compared as unsigned numbers.
module sorted_deadline_timer_queue_top #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [sdtq_pkg::CmdW-1:0]     cmd_i,
  input  logic [sdtq_pkg::IdW-1:0]      timer_id_i,
  input  logic [sdtq_pkg::DelayW-1:0]   delay_us_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sdtq_pkg::PeriodW-1:0]  cfg_data_i,
  output logic                          res_strobe_o,
  output logic [sdtq_pkg::KindW-1:0]    kind_o,
  output logic [sdtq_pkg::IdW-1:0]      expired_id_o,
  output logic                          last_o
);

  sdtq_pkg::state_e state_q, state_d;

  logic [sdtq_pkg::TimeW-1:0]   time_q, time_d;
  logic [sdtq_pkg::PeriodW-1:0] period_q;
  logic [sdtq_pkg::IdW-1:0]     ins_id_q, ins_id_d;
  logic [sdtq_pkg::TimeW-1:0]   ins_dl_q, ins_dl_d;
  logic [sdtq_pkg::PopCntW-1:0] pop_cnt_q, pop_cnt_d;

  logic                        res_strobe_q, res_strobe_d;
  sdtq_pkg::kind_e             kind_q, kind_d;
  logic [sdtq_pkg::IdW-1:0]    res_id_q, res_id_d;
  logic                        last_q, last_d;

  sdtq_pkg::cell_ctl_t ctl;
  logic                pop;

  sdtq_pkg::entry_t entries [TIMER_SLOTS];
  logic             open_flags [TIMER_SLOTS];
  logic             kill_chain [TIMER_SLOTS+1];

  logic accept;
  logic id_ok;
  logic head_due;
  logic next_due;

  assign busy         = (state_q != sdtq_pkg::ST_IDLE);
  assign accept       = start & ~busy;
  assign cfg_ready_o  = 1'b1;
  assign res_strobe_o = res_strobe_q;
  assign kind_o       = kind_q;
  assign expired_id_o = res_id_q;
  assign last_o       = last_q;

  assign id_ok = (32'(timer_id_i) < TIMER_SLOTS);

  // The head cell decides whether a timer pops; the second cell and the pop count
  // decide whether the popped one is the last of the expire.
  assign head_due = entries[0].valid & (entries[0].dl <= time_q);
  assign next_due = entries[1].valid & (entries[1].dl <= time_q);

  // A pop starts the move toward the head at cell 0.
  assign kill_chain[0] = pop;

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    sdtq_pkg::entry_t left_entry;
    sdtq_pkg::entry_t right_entry;
    logic             left_open;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_open  = 1'b0;
    end else begin : g_body
      assign left_entry = entries[i-1];
      assign left_open  = open_flags[i-1];
    end

    if (i == TIMER_SLOTS - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    sdtq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .left_i      (left_entry),
      .right_i     (right_entry),
      .left_open_i (left_open),
      .kill_i      (kill_chain[i]),
      .entry_o     (entries[i]),
      .open_o      (open_flags[i]),
      .kill_o      (kill_chain[i+1])
    );
  end

  always_comb begin
    state_d      = state_q;
    time_d       = time_q;
    ins_id_d     = ins_id_q;
    ins_dl_d     = ins_dl_q;
    pop_cnt_d    = pop_cnt_q;
    res_strobe_d = 1'b0;
    kind_d       = kind_q;
    res_id_d     = res_id_q;
    last_d       = last_q;
    pop          = 1'b0;
    ctl          = '{remove: 1'b0, insert: 1'b0, id: ins_id_q, dl: ins_dl_q};

    unique case (state_q)
      sdtq_pkg::ST_IDLE: begin
        if (accept) begin
          ins_id_d = timer_id_i;
          ins_dl_d = time_q + sdtq_pkg::TimeW'(delay_us_i);
          unique case (sdtq_pkg::cmd_e'(cmd_i))
            sdtq_pkg::CMD_TICK: begin
              time_d       = time_q + sdtq_pkg::TimeW'(period_q);
              res_strobe_d = 1'b1;
              kind_d       = sdtq_pkg::KIND_ACK;
              res_id_d     = '0;
              last_d       = 1'b1;
            end
            sdtq_pkg::CMD_ADD: begin
              // Drop any queued copy first; the insert follows next cycle.
              ctl.remove = id_ok;
              ctl.id     = timer_id_i;
              if (id_ok) begin
                state_d = sdtq_pkg::ST_INSERT;
              end else begin
                res_strobe_d = 1'b1;
                kind_d       = sdtq_pkg::KIND_ACK;
                res_id_d     = '0;
                last_d       = 1'b1;
              end
            end
            sdtq_pkg::CMD_DELETE: begin
              ctl.remove   = id_ok;
              ctl.id       = timer_id_i;
              res_strobe_d = 1'b1;
              kind_d       = sdtq_pkg::KIND_ACK;
              res_id_d     = '0;
              last_d       = 1'b1;
            end
            sdtq_pkg::CMD_EXPIRE: begin
              pop_cnt_d = '0;
              state_d   = sdtq_pkg::ST_EXPIRE;
            end
            default: begin
              state_d = sdtq_pkg::ST_IDLE;
            end
          endcase
        end
      end

      sdtq_pkg::ST_INSERT: begin
        ctl.insert   = 1'b1;
        res_strobe_d = 1'b1;
        kind_d       = sdtq_pkg::KIND_ACK;
        res_id_d     = '0;
        last_d       = 1'b1;
        state_d      = sdtq_pkg::ST_IDLE;
      end

      sdtq_pkg::ST_EXPIRE: begin
        res_strobe_d = 1'b1;
        if (head_due) begin
          pop       = 1'b1;
          kind_d    = sdtq_pkg::KIND_EXPIRED;
          res_id_d  = entries[0].id;
          pop_cnt_d = pop_cnt_q + 1'b1;
          last_d    = (pop_cnt_q == sdtq_pkg::PopCntW'(sdtq_pkg::MaxPops - 1)) | ~next_due;
          if (last_d) begin
            state_d = sdtq_pkg::ST_IDLE;
          end
        end else begin
          // Only reached on the first cycle: later cycles stop on the last pop.
          kind_d   = sdtq_pkg::KIND_NONE;
          res_id_d = '0;
          last_d   = 1'b1;
          state_d  = sdtq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sdtq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sdtq_pkg::ST_IDLE;
      time_q       <= '0;
      period_q     <= sdtq_pkg::TickPeriodReset;
      pop_cnt_q    <= '0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      time_q       <= time_d;
      pop_cnt_q    <= pop_cnt_d;
      res_strobe_q <= res_strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        period_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ins_id_q <= ins_id_d;
    ins_dl_q <= ins_dl_d;
    kind_q   <= kind_d;
    res_id_q <= res_id_d;
    last_q   <= last_d;
  end

endmodule

// ----- tb/sdtq_checker.sv -----
// Scoreboard for the sorted deadline timer queue: models the clock and the
// deadline-ordered queue and compares every result transaction in order.
// Depends on sdtq_pkg for widths, command codes and result kinds.
`timescale 1ns / 1ps

module sdtq_checker #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [sdtq_pkg::CmdW-1:0]     cmd_i,
  input  logic [sdtq_pkg::IdW-1:0]      timer_id_i,
  input  logic [sdtq_pkg::DelayW-1:0]   delay_us_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [sdtq_pkg::PeriodW-1:0]  cfg_data_i,
  input  logic                          res_strobe_i,
  input  logic [sdtq_pkg::KindW-1:0]    kind_i,
  input  logic [sdtq_pkg::IdW-1:0]      expired_id_i,
  input  logic                          last_i,
  output int unsigned                   err_count_o,
  output int unsigned                   pending_o
);
  import sdtq_pkg::*;

  typedef struct packed {
    kind_e          kind;
    logic [IdW-1:0] id;
    logic           last;
  } reply_t;

  reply_t              reply_q[$];
  logic [TimeW-1:0]    now_us;
  logic [TimeW-1:0]    deadline_us [TIMER_SLOTS];
  logic [IdW-1:0]      timer_order [TIMER_SLOTS];
  int unsigned         queued_cnt;
  logic [TIMER_SLOTS-1:0] queued;
  logic [PeriodW-1:0]  period_us;
  int unsigned         mismatches;

  function automatic void unlink_timer(input logic [IdW-1:0] id);
    int unsigned i;
    int unsigned j;
    if (!queued[id]) return;
    for (i = 0; i < queued_cnt; i++) begin
      if (timer_order[i] == id) begin
        for (j = i; j + 1 < queued_cnt; j++) timer_order[j] = timer_order[j+1];
        queued_cnt--;
        break;
      end
    end
    queued[id] = 1'b0;
  endfunction

  function automatic void link_timer(input logic [IdW-1:0] id, input logic [TimeW-1:0] dl);
    int unsigned pos;
    int unsigned j;
    pos = 0;
    if (queued_cnt >= TIMER_SLOTS) return;
    // Insert ahead of the first entry that is due at the same time or later.
    while (pos < queued_cnt && dl > deadline_us[timer_order[pos]]) pos++;
    for (j = queued_cnt; j > pos; j--) timer_order[j] = timer_order[j-1];
    timer_order[pos] = id;
    deadline_us[id] = dl;
    queued_cnt++;
    queued[id] = 1'b1;
  endfunction

  function automatic void apply_command(input logic [CmdW-1:0] cmd, input logic [IdW-1:0] id,
                                        input logic [DelayW-1:0] delay);
    logic [IdW-1:0] popped [MaxPops];
    logic [IdW-1:0] head;
    int unsigned    n;
    int unsigned    k;
    n = 0;
    case (cmd_e'(cmd))
      CMD_TICK: now_us = now_us + TimeW'(period_us);
      CMD_ADD: begin
        if (id < TIMER_SLOTS) begin
          unlink_timer(id);
          link_timer(id, now_us + TimeW'(delay));
        end
      end
      CMD_DELETE: begin
        if (id < TIMER_SLOTS) unlink_timer(id);
      end
      default: begin
        while (n < MaxPops && queued_cnt > 0) begin
          head = timer_order[0];
          if (deadline_us[head] > now_us) break;
          unlink_timer(head);
          popped[n] = head;
          n++;
        end
      end
    endcase
    if (cmd_e'(cmd) != CMD_EXPIRE) begin
      reply_q.push_back('{kind: KIND_ACK, id: '0, last: 1'b1});
    end else if (n == 0) begin
      reply_q.push_back('{kind: KIND_NONE, id: '0, last: 1'b1});
    end else begin
      for (k = 0; k < n; k++)
        reply_q.push_back('{kind: KIND_EXPIRED, id: popped[k], last: (k == n - 1)});
    end
  endfunction

  function automatic void check_result();
    reply_t want;
    if (reply_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t sdtq_checker: unexpected result kind %0d id %0d last %0d",
                 $realtime, kind_i, expired_id_i, last_i);
      return;
    end
    want = reply_q.pop_front();
    if (kind_i !== want.kind || expired_id_i !== want.id || last_i !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t sdtq_checker: expected kind %0d id %0d last %0d,",
                  " got kind %0d id %0d last %0d"},
                 $realtime, want.kind, want.id, want.last, kind_i, expired_id_i, last_i);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_us     = '0;
      queued_cnt = 0;
      queued     = '0;
      period_us  = TickPeriodReset;
      mismatches = 0;
      reply_q.delete();
    end else begin
      if (res_strobe_i) check_result();
      if (start_i && !busy_i) apply_command(cmd_i, timer_id_i, delay_us_i);
      if (cfg_valid_i && cfg_ready_i) period_us = cfg_data_i;
    end
    err_count_o <= mismatches;
    pending_o   <= reply_q.size();
  end

endmodule

// ----- tb/tb_sorted_deadline_timer_queue_top.sv -----
// Top of the sorted deadline timer queue testbench: clock, reset, command and
// tick period stimulus, and the final verdict.
// Depends on sdtq_pkg, sorted_deadline_timer_queue_top and sdtq_checker.
`timescale 1ns / 1ps

module tb_sorted_deadline_timer_queue_top;
  import sdtq_pkg::*;

  localparam int unsigned Slots = 16;
  // Random items per tick period setting; with the directed commands, five
  // settings give about 370 items.
  localparam int unsigned PhaseItems = 69;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [CmdW-1:0]     cmd_i;
  logic [IdW-1:0]      timer_id_i;
  logic [DelayW-1:0]   delay_us_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [PeriodW-1:0]  cfg_data_i;
  logic                res_strobe_o;
  logic [KindW-1:0]    kind_o;
  logic [IdW-1:0]      expired_id_o;
  logic                last_o;

  int unsigned         err_count;
  int unsigned         pending;
  // When clear, the command side issues back to back without random gaps.
  bit                  idle_on;
  logic [PeriodW-1:0]  period_now;

  sorted_deadline_timer_queue_top #(
    .TIMER_SLOTS(Slots)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .timer_id_i   (timer_id_i),
    .delay_us_i   (delay_us_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .res_strobe_o (res_strobe_o),
    .kind_o       (kind_o),
    .expired_id_o (expired_id_o),
    .last_o       (last_o)
  );

  // The checker sees exactly what the block sees, at the same clock edges.
  sdtq_checker #(
    .TIMER_SLOTS(Slots)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd_i),
    .timer_id_i   (timer_id_i),
    .delay_us_i   (delay_us_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .res_strobe_i (res_strobe_o),
    .kind_i       (kind_o),
    .expired_id_i (expired_id_o),
    .last_i       (last_o),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Safety net: a hung handshake or a missing result ends the run here.
  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Issues one command transaction. The task is entered just after a rising
  // edge and returns just after the edge at which the block accepted the
  // command, so that every call drives start exactly once per time step.
  task automatic issue(input cmd_e c, input logic [IdW-1:0] id, input logic [DelayW-1:0] d);
    while (idle_on && $urandom_range(99) < 28) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    cmd_i      <= c;
    timer_id_i <= id;
    delay_us_i <= d;
    // busy read right after the edge is the value the block sampled there.
    do @(posedge clk_i); while (busy);
  endtask

  // Stops issuing and waits until every predicted result has been seen and
  // the block is idle. The first edge lets the checker count the transaction
  // that was accepted just before the call.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the tick period; only called while the block is idle.
  task automatic write_period(input logic [PeriodW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    period_now = v;
    @(posedge clk_i);
  endtask

  // Delays are mostly at most four tick periods, often an exact multiple, so timers
  // actually come due and equal deadlines are common; a few are wide or extreme.
  function automatic logic [DelayW-1:0] pick_delay(input logic [PeriodW-1:0] p);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return DelayW'($urandom_range(3)) * DelayW'(p);
    if (r < 75) return DelayW'($urandom_range(4 * p));
    if (r < 85) return DelayW'($urandom);
    if (r < 95) return '0;
    return '1;
  endfunction

  // Mix of commands: adds dominate so the queue fills up, ticks and expires
  // keep it draining, deletes hit both queued and absent timers.
  task automatic issue_random();
    int unsigned r;
    cmd_e        c;
    r = $urandom_range(99);
    if (r < 25) c = CMD_TICK;
    else if (r < 65) c = CMD_ADD;
    else if (r < 80) c = CMD_DELETE;
    else c = CMD_EXPIRE;
    issue(c, IdW'($urandom_range(15)), pick_delay(period_now));
  endtask

  initial begin
    int unsigned i;
    int unsigned p;
    logic [PeriodW-1:0] v;

    start       <= 1'b0;
    cmd_i       <= CMD_TICK;
    timer_id_i  <= '0;
    delay_us_i  <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    idle_on     = 1'b1;
    period_now  = TickPeriodReset;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with the reset tick period of 1000 us.
    // Expire on an empty queue must answer "nothing expired".
    issue(CMD_EXPIRE, 4'd0, '0);
    // Deleting a timer that is not queued is only acknowledged.
    issue(CMD_DELETE, 4'd5, '0);
    // Zero delay, the largest delay, and two equal deadlines (newest first).
    issue(CMD_ADD, 4'd0, '0);
    issue(CMD_ADD, 4'd15, '1);
    issue(CMD_ADD, 4'd3, 32'd1000);
    issue(CMD_ADD, 4'd7, 32'd1000);
    // Adding a timer that is already queued moves it to its new deadline.
    issue(CMD_ADD, 4'd3, 32'd500);
    issue(CMD_TICK, 4'd0, '0);
    // Pops timers 0, 3 and 7; timer 15 stays far in the future.
    issue(CMD_EXPIRE, 4'd0, '0);
    // Fill all sixteen slots with due timers, re-adding timer 15 last, so
    // that one expire reports the largest possible number of results.
    for (i = 0; i < Slots; i++) issue(CMD_ADD, IdW'(i), '0);
    issue(CMD_EXPIRE, 4'd0, '0);
    drain();

    // Random part: one phase per tick period setting. The extremes of the
    // register are among them, and zero leaves the clock standing still.
    for (p = 0; p < 5; p++) begin
      case (p)
        0:       v = 20'd1;
        1:       v = 20'hFFFFF;
        2:       v = '0;
        3:       v = PeriodW'($urandom_range(1000000, 1));
        default: v = 20'd1000000;
      endcase
      write_period(v);
      // One phase runs with commands back to back.
      idle_on = (p != 1);
      for (i = 0; i < PhaseItems; i++) begin
        // Once in the middle of a phase, hold off until everything is back.
        if (p == 3 && i == PhaseItems / 2) drain();
        issue_random();
      end
      drain();
    end

    // Leave room for any stray result before the verdict.
    repeat (8) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
